### hdl/cetc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cetc_pkg
// Shared constants, types and the month offset table for the calendar and
// epoch time converter.
// ----------------------------------------------------------------------------
package cetc_pkg;

  // width of the shared compare-subtract unit
  localparam int CMP_W = 33;

  localparam int STAMP_W = 33;
  localparam int CNT_W = 4;

  localparam logic [16:0] SECS_PER_DAY = 17'd86400;
  localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
  localparam logic [5:0] SECS_PER_MIN = 6'd60;
  localparam int DAYS_PER_YEAR = 365;

  // quotient bits of the restoring divisions
  localparam int DAY_Q_W = 16;
  localparam int HOUR_Q_W = 5;
  localparam int MIN_Q_W = 6;
  localparam int MON_STEPS = 4;
  localparam logic [3:0] LAST_MONTH_IDX = 4'd11;

  localparam logic [9:0] MILLIS_MAX = 10'd999;
  localparam logic [12:0] YEAR_MAX = 13'd4095;

  typedef struct packed {
    logic ge;
    logic [CMP_W-1:0] diff;
  } cmp_res_t;

  // days from 1 january to the first of month index m (0..12, above clamps)
  function automatic logic [8:0] month_start_days(input logic [3:0] m, input logic leap);
    logic [8:0] base;
    case (m)
      4'd0: base = 9'd0;
      4'd1: base = 9'd31;
      4'd2: base = 9'd59;
      4'd3: base = 9'd90;
      4'd4: base = 9'd120;
      4'd5: base = 9'd151;
      4'd6: base = 9'd181;
      4'd7: base = 9'd212;
      4'd8: base = 9'd243;
      4'd9: base = 9'd273;
      4'd10: base = 9'd304;
      4'd11: base = 9'd334;
      default: base = 9'd365;
    endcase
    if (leap && (m >= 4'd2)) begin
      base = base + 9'd1;
    end
    return base;
  endfunction

endpackage

### hdl/cetc_cmpsub.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cetc_cmpsub
// Shared compare-subtract unit: flags a >= b and gives a - b. Serves the
// restoring divisions and the year and month searches.
// ----------------------------------------------------------------------------
module cetc_cmpsub import cetc_pkg::*; (
  input  logic [CMP_W-1:0] a,
  input  logic [CMP_W-1:0] b,
  output cmp_res_t         res
);

  logic [CMP_W:0] wide;

  assign wide = {1'b0, a} - {1'b0, b};
  assign res.ge = ~wide[CMP_W];
  assign res.diff = wide[CMP_W-1:0];

endmodule

### hdl/calendar_epoch_time_converter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calendar_epoch_time_converter_core
// Converts a calendar date plus seconds into seconds since the epoch year,
// or a stamp into calendar fields.
// Date to stamp runs through the check, multiply and add states; out of range
//   ends after the check; stamp to date is serialised on the shared unit: 16
//   day-division steps, the year and month searches, 5 hour and 6 minute steps.
// One request at a time; busy falls in the strobe cycle. Receiver cannot stall.
// Reset: synchronous, active low, clears sequencer and strobe; no clear pass.
// ----------------------------------------------------------------------------
module calendar_epoch_time_converter_core import cetc_pkg::*; #(
  parameter int EPOCH_YEAR = 1970,
  parameter int TABLE_YEARS = 128
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic                 in_mode,
  input  logic [11:0]          in_year,
  input  logic [3:0]           in_month,
  input  logic [4:0]           in_day,
  input  logic [31:0]          in_seconds,
  input  logic [9:0]           in_millis,
  output logic                 out_valid,
  output logic [STAMP_W-1:0]   out_stamp_seconds,
  output logic [9:0]           out_stamp_millis,
  output logic [11:0]          out_year,
  output logic [3:0]           out_month,
  output logic [4:0]           out_day,
  output logic [4:0]           out_hour,
  output logic [5:0]           out_minute,
  output logic [5:0]           out_second,
  output logic [9:0]           out_millisecond,
  output logic [8:0]           out_day_of_year,
  output logic                 out_of_range
);

  localparam int IDXW = $clog2(TABLE_YEARS + 1);
  localparam int LEAP_BASE = (EPOCH_YEAR + 3) / 4;
  localparam int LEAPS_END = (EPOCH_YEAR + TABLE_YEARS + 3) / 4 - LEAP_BASE;
  localparam int END_DAYS = DAYS_PER_YEAR * TABLE_YEARS + LEAPS_END;
  localparam int DAYW = $clog2(END_DAYS + 400);
  localparam int PW = DAYW + 17;
  localparam int SW = ((PW > 32) ? PW : 32) + 1;
  localparam logic [63:0] END_SECS = 64'(END_DAYS) * 64'(SECS_PER_DAY);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_CHECK = 4'd1;
  localparam logic [3:0] ST_MUL   = 4'd2;
  localparam logic [3:0] ST_ADD   = 4'd3;
  localparam logic [3:0] ST_DDIV  = 4'd4;
  localparam logic [3:0] ST_YEAR  = 4'd5;
  localparam logic [3:0] ST_YREM  = 4'd6;
  localparam logic [3:0] ST_MON   = 4'd7;
  localparam logic [3:0] ST_MREM  = 4'd8;
  localparam logic [3:0] ST_HDIV  = 4'd9;
  localparam logic [3:0] ST_NDIV  = 4'd10;

  function automatic logic [DAYW-1:0] year_days(input logic [IDXW-1:0] idx);
    logic [12:0] y3;
    logic [DAYW-1:0] lp;
    y3 = 13'(EPOCH_YEAR) + 13'(idx) + 13'd3;
    lp = DAYW'(y3 >> 2) - DAYW'(LEAP_BASE);
    return DAYW'(idx) * DAYW'(DAYS_PER_YEAR) + lp;
  endfunction

  logic [3:0]         state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               valid_r, valid_nxt;

  logic               mode_r, mode_nxt;
  logic [11:0]        year_r, year_nxt;
  logic [3:0]         month_r, month_nxt;
  logic [4:0]         day_r, day_nxt;
  logic [31:0]        secs_r, secs_nxt;
  logic [9:0]         millis_r, millis_nxt;
  logic [31:0]        rem_r, rem_nxt;
  logic [DAY_Q_W-1:0] quo_r, quo_nxt;
  logic [IDXW-1:0]    idx_r, idx_nxt;
  logic [3:0]         mon_r, mon_nxt;
  logic [8:0]         dayrem_r, dayrem_nxt;
  logic [DAYW-1:0]    days_r, days_nxt;
  logic [PW-1:0]      prod_r, prod_nxt;

  logic [STAMP_W-1:0] stamp_r, stamp_nxt;
  logic [9:0]         smillis_r, smillis_nxt;
  logic [11:0]        oyear_r, oyear_nxt;
  logic [3:0]         omonth_r, omonth_nxt;
  logic [4:0]         oday_r, oday_nxt;
  logic [4:0]         ohour_r, ohour_nxt;
  logic [5:0]         omin_r, omin_nxt;
  logic [5:0]         osec_r, osec_nxt;
  logic [9:0]         omillis_r, omillis_nxt;
  logic [8:0]         odoy_r, odoy_nxt;
  logic               oor_r, oor_nxt;

  logic [CMP_W-1:0]   unit_a, unit_b;
  cmp_res_t           unit_res;

  logic [IDXW-1:0]    year_cand;
  logic [3:0]         mon_cand;
  logic [12:0]        year_sum;
  logic               leap1;
  logic               in_range0;
  logic [IDXW-1:0]    idx0;
  logic [3:0]         mm0;
  logic [4:0]         dd0;
  logic               over_end;
  logic [SW-1:0]      stamp_sum;
  logic [31:0]        rem_step;

  cetc_cmpsub u_cmpsub (
    .a   (unit_a),
    .b   (unit_b),
    .res (unit_res)
  );

  assign year_cand = idx_r | (IDXW'(1) << cnt_r);
  assign mon_cand = mon_r | (4'(1) << cnt_r);
  assign year_sum = 13'(EPOCH_YEAR) + 13'(idx_r);
  assign leap1 = (year_sum[1:0] == 2'b00);
  assign in_range0 = ({1'b0, year_r} >= 13'(EPOCH_YEAR)) &&
                     ({1'b0, year_r} < 13'(EPOCH_YEAR + TABLE_YEARS));
  assign idx0 = IDXW'({1'b0, year_r} - 13'(EPOCH_YEAR));
  assign mm0 = (month_r == 4'd0) ? 4'd0 : month_r - 4'd1;
  assign dd0 = (day_r == 5'd0) ? 5'd0 : day_r - 5'd1;
  assign over_end = ({32'd0, secs_r} > END_SECS) ||
                    (({32'd0, secs_r} == END_SECS) && (millis_r != 10'd0));
  assign stamp_sum = SW'(prod_r) + SW'(secs_r);
  assign rem_step = unit_res.ge ? unit_res.diff[31:0] : rem_r;

  // operand select for the shared unit
  always_comb begin
    unit_a = '0;
    unit_b = '0;
    case (state_r)
      ST_DDIV: begin
        unit_a = CMP_W'(rem_r);
        unit_b = CMP_W'(SECS_PER_DAY) << cnt_r;
      end
      ST_YEAR: begin
        unit_a = CMP_W'(quo_r);
        unit_b = CMP_W'(year_days(year_cand));
      end
      ST_YREM: begin
        unit_a = CMP_W'(quo_r);
        unit_b = CMP_W'(year_days(idx_r));
      end
      ST_MON: begin
        unit_a = CMP_W'(dayrem_r);
        unit_b = CMP_W'(month_start_days(mon_cand, leap1));
      end
      ST_MREM: begin
        unit_a = CMP_W'(dayrem_r);
        unit_b = CMP_W'(month_start_days(mon_r, leap1));
      end
      ST_HDIV: begin
        unit_a = CMP_W'(rem_r);
        unit_b = CMP_W'(SECS_PER_HOUR) << cnt_r;
      end
      ST_NDIV: begin
        unit_a = CMP_W'(rem_r);
        unit_b = CMP_W'(SECS_PER_MIN) << cnt_r;
      end
      default: begin
        unit_a = '0;
        unit_b = '0;
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    valid_nxt = 1'b0;
    mode_nxt = mode_r;
    year_nxt = year_r;
    month_nxt = month_r;
    day_nxt = day_r;
    secs_nxt = secs_r;
    millis_nxt = millis_r;
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    idx_nxt = idx_r;
    mon_nxt = mon_r;
    dayrem_nxt = dayrem_r;
    days_nxt = days_r;
    prod_nxt = prod_r;
    stamp_nxt = stamp_r;
    smillis_nxt = smillis_r;
    oyear_nxt = oyear_r;
    omonth_nxt = omonth_r;
    oday_nxt = oday_r;
    ohour_nxt = ohour_r;
    omin_nxt = omin_r;
    osec_nxt = osec_r;
    omillis_nxt = omillis_r;
    odoy_nxt = odoy_r;
    oor_nxt = oor_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          mode_nxt = in_mode;
          year_nxt = in_year;
          month_nxt = in_month;
          day_nxt = in_day;
          secs_nxt = in_seconds;
          millis_nxt = (in_millis > MILLIS_MAX) ? MILLIS_MAX : in_millis;
          stamp_nxt = '0;
          smillis_nxt = '0;
          oyear_nxt = '0;
          omonth_nxt = '0;
          oday_nxt = '0;
          ohour_nxt = '0;
          omin_nxt = '0;
          osec_nxt = '0;
          omillis_nxt = '0;
          odoy_nxt = '0;
          oor_nxt = 1'b0;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (!mode_r) begin
          if (!in_range0) begin
            oor_nxt = 1'b1;
            valid_nxt = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            days_nxt = year_days(idx0) +
                       DAYW'(month_start_days(mm0, year_r[1:0] == 2'b00)) + DAYW'(dd0);
            state_nxt = ST_MUL;
          end
        end else if (over_end) begin
          oor_nxt = 1'b1;
          valid_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          rem_nxt = secs_r;
          quo_nxt = '0;
          cnt_nxt = CNT_W'(DAY_Q_W - 1);
          state_nxt = ST_DDIV;
        end
      end
      ST_MUL: begin
        prod_nxt = PW'(days_r) * PW'(SECS_PER_DAY);
        state_nxt = ST_ADD;
      end
      ST_ADD: begin
        stamp_nxt = (stamp_sum > SW'({STAMP_W{1'b1}})) ? {STAMP_W{1'b1}} :
                    stamp_sum[STAMP_W-1:0];
        smillis_nxt = millis_r;
        valid_nxt = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_DDIV: begin
        rem_nxt = rem_step;
        quo_nxt = {quo_r[DAY_Q_W-2:0], unit_res.ge};
        if (cnt_r == '0) begin
          idx_nxt = '0;
          cnt_nxt = CNT_W'(IDXW - 1);
          state_nxt = ST_YEAR;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      ST_YEAR: begin
        if (unit_res.ge && (year_cand <= IDXW'(TABLE_YEARS))) begin
          idx_nxt = year_cand;
        end
        if (cnt_r == '0) begin
          state_nxt = ST_YREM;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      ST_YREM: begin
        dayrem_nxt = unit_res.diff[8:0];
        odoy_nxt = unit_res.diff[8:0] + 9'd1;
        oyear_nxt = (year_sum > YEAR_MAX) ? YEAR_MAX[11:0] : year_sum[11:0];
        mon_nxt = '0;
        cnt_nxt = CNT_W'(MON_STEPS - 1);
        state_nxt = ST_MON;
      end
      ST_MON: begin
        if (unit_res.ge && (mon_cand <= LAST_MONTH_IDX)) begin
          mon_nxt = mon_cand;
        end
        if (cnt_r == '0) begin
          state_nxt = ST_MREM;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      ST_MREM: begin
        oday_nxt = unit_res.diff[4:0] + 5'd1;
        omonth_nxt = mon_r + 4'd1;
        cnt_nxt = CNT_W'(HOUR_Q_W - 1);
        state_nxt = ST_HDIV;
      end
      ST_HDIV: begin
        rem_nxt = rem_step;
        ohour_nxt = {ohour_r[HOUR_Q_W-2:0], unit_res.ge};
        if (cnt_r == '0) begin
          cnt_nxt = CNT_W'(MIN_Q_W - 1);
          state_nxt = ST_NDIV;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      ST_NDIV: begin
        rem_nxt = rem_step;
        omin_nxt = {omin_r[MIN_Q_W-2:0], unit_res.ge};
        if (cnt_r == '0) begin
          osec_nxt = rem_step[5:0];
          omillis_nxt = millis_r;
          valid_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r <= '0;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r <= mode_nxt;
    year_r <= year_nxt;
    month_r <= month_nxt;
    day_r <= day_nxt;
    secs_r <= secs_nxt;
    millis_r <= millis_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    idx_r <= idx_nxt;
    mon_r <= mon_nxt;
    dayrem_r <= dayrem_nxt;
    days_r <= days_nxt;
    prod_r <= prod_nxt;
    stamp_r <= stamp_nxt;
    smillis_r <= smillis_nxt;
    oyear_r <= oyear_nxt;
    omonth_r <= omonth_nxt;
    oday_r <= oday_nxt;
    ohour_r <= ohour_nxt;
    omin_r <= omin_nxt;
    osec_r <= osec_nxt;
    omillis_r <= omillis_nxt;
    odoy_r <= odoy_nxt;
    oor_r <= oor_nxt;
  end

  assign busy = (state_r != ST_IDLE);
  assign out_valid = valid_r;
  assign out_stamp_seconds = stamp_r;
  assign out_stamp_millis = smillis_r;
  assign out_year = oyear_r;
  assign out_month = omonth_r;
  assign out_day = oday_r;
  assign out_hour = ohour_r;
  assign out_minute = omin_r;
  assign out_second = osec_r;
  assign out_millisecond = omillis_r;
  assign out_day_of_year = odoy_r;
  assign out_of_range = oor_r;

  // checks
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_request_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("request taken without going busy");

  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_of_range) |-> ((out_stamp_seconds == '0) && (out_year == '0) &&
      (out_month == '0) && (out_day_of_year == '0)))
    else $error("out of range result carries nonzero fields");

  a_time_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_hour < 5'd24) && (out_minute < 6'd60) && (out_second < 6'd60) &&
      (out_month <= 4'd12)))
    else $error("time of day field out of range");

endmodule
